/* hdl/rcv_pkg.sv */
package rcv_pkg;

   localparam int WORD_W = 32;
   localparam int LEN_W  = 16;
   localparam int PT_W   = 8;
   localparam int VER_W  = 2;

   localparam logic [PT_W-1:0]  PT_SR       = 8'd200;
   localparam logic [PT_W-1:0]  PT_RR       = 8'd201;
   localparam logic [PT_W-1:0]  PT_APP      = 8'd204;
   localparam logic [VER_W-1:0] HDR_VERSION = 2'd2;

   typedef enum logic [1:0] {
      STATUS_HDR_FAIL = 2'd0,
      STATUS_UNKNOWN  = 2'd1,
      STATUS_OK       = 2'd2
   } status_type;

   // per-packet walk state carried between words
   typedef struct packed {
      logic [LEN_W-1:0] words_left;
      logic             at_first_header;
      logic             padding_seen;
      logic             header_bad;
      logic             type_unknown;
      logic             first_was_sr;
   } walk_state_type;

   localparam walk_state_type WALK_RESET = '{
      words_left:      '0,
      at_first_header: 1'b1,
      padding_seen:    1'b0,
      header_bad:      1'b0,
      type_unknown:    1'b0,
      first_was_sr:    1'b0
   };

endpackage

/* hdl/rcv_channels.sv */
interface rcv_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;
   logic        last;

   modport source (output valid, output word, output last, input ready);
   modport sink   (input valid, input word, input last, output ready);
endinterface

interface rcv_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       is_sender;

   modport source (output valid, output status, output is_sender, input ready);
   modport sink   (input valid, input status, input is_sender, output ready);
endinterface

/* hdl/rcv_word_check.sv */
module rcv_word_check (
   input  rcv_pkg::walk_state_type    state,
   input  logic [rcv_pkg::WORD_W-1:0] word,
   input  logic                       last,
   output rcv_pkg::walk_state_type    state_next,
   output rcv_pkg::status_type        status,
   output logic                       is_sender
);
   import rcv_pkg::*;

   logic [VER_W-1:0] ver;
   logic             pad;
   logic [PT_W-1:0]  pt;
   logic [LEN_W-1:0] len;
   walk_state_type   walked;
   logic             bad_final;

   assign ver = word[31:30];
   assign pad = word[29];
   assign pt  = word[23:16];
   assign len = word[15:0];

   always_comb begin
      walked = state;
      if (state.words_left == '0) begin
         if (state.at_first_header) begin
            if ((pt != PT_SR) && (pt != PT_RR)) begin
               walked.header_bad = 1'b1;
            end
            walked.first_was_sr    = (pt == PT_SR);
            walked.at_first_header = 1'b0;
         end
         // a padded sub-packet must be the final one
         if ((ver != HDR_VERSION) || state.padding_seen) begin
            walked.header_bad = 1'b1;
         end
         walked.padding_seen = pad;
         if ((pt < PT_SR) || (pt > PT_APP)) begin
            walked.type_unknown = 1'b1;
         end
         walked.words_left = len;
      end else begin
         walked.words_left = state.words_left - 1'b1;
      end
   end

   // length overshoot shows up as body words still due on the last beat
   assign bad_final = walked.header_bad || (walked.words_left != '0);

   always_comb begin
      if (bad_final) begin
         status = STATUS_HDR_FAIL;
      end else if (walked.type_unknown) begin
         status = STATUS_UNKNOWN;
      end else begin
         status = STATUS_OK;
      end
   end

   assign is_sender  = walked.first_was_sr;
   assign state_next = last ? WALK_RESET : walked;

endmodule

/* hdl/rtcp_compound_validator_core.sv */
// Compound RTCP packet checker. Packet words arrive one beat per cycle on req_if with the
// final word marked by last; one status beat leaves on rsp_if for every packet, carrying
// header failure, unknown sub-packet type or ok, plus whether the first sub-packet was a
// sender report. A word is taken every cycle unless a last word is waiting in the input
// register; the result reaches rsp_if through the input register, then the result register.
// The single result register sets the stall behavior: a last word waits in the input
// register only while an earlier result is still held on rsp_if.
module rtcp_compound_validator_core (
   input logic      clock,
   input logic      reset,
   rcv_req_if.sink  req_if,
   rcv_rsp_if.source rsp_if
);
   import rcv_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [WORD_W-1:0]   in_word_ff, in_word_in;
   logic                in_last_ff, in_last_in;
   walk_state_type      state_ff, state_in;
   logic                out_valid_ff, out_valid_in;
   status_type          out_status_ff, out_status_in;
   logic                out_sender_ff, out_sender_in;

   walk_state_type      state_next;
   status_type          chk_status;
   logic                chk_sender;
   logic                advance;
   logic                take;

   rcv_word_check u_check (
      .state      (state_ff),
      .word       (in_word_ff),
      .last       (in_last_ff),
      .state_next (state_next),
      .status     (chk_status),
      .is_sender  (chk_sender)
   );

   // a non-last word never needs the result register
   assign advance = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign take = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_word_in    = in_word_ff;
      in_last_in    = in_last_ff;
      state_in      = state_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_sender_in = out_sender_ff;

      if (advance) begin
         in_valid_in = 1'b0;
         state_in    = state_next;
      end
      if (take) begin
         in_valid_in = 1'b1;
         in_word_in  = req_if.word;
         in_last_in  = req_if.last;
      end

      if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && in_last_ff) begin
         out_valid_in  = 1'b1;
         out_status_in = chk_status;
         out_sender_in = chk_sender;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= WALK_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_word_ff    <= in_word_in;
      in_last_ff    <= in_last_in;
      out_status_ff <= out_status_in;
      out_sender_ff <= out_sender_in;
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.status    = out_status_ff;
   assign rsp_if.is_sender = out_sender_ff;

endmodule
